// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by gps_fix_to_local_plane.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gfl_pkg.sv -----
// types, constants and constant tables of the gps fix to local plane block
package gfl_pkg;

    localparam int CordicSteps = 60;

    localparam logic [63:0] OneQ60      = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PiQ62       = 64'hC90F_DAA2_2168_C234;
    localparam logic [63:0] PiQ60       = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] HalfPiQ60   = PiQ60 >> 1;
    localparam logic [63:0] RadiusMm    = 64'd6378137000;
    localparam logic [63:0] TwoRadiusMm = 64'd12756274000;
    localparam logic [63:0] UnitsHalfTurn = 64'd1800000000;
    localparam logic signed [63:0] OutLimit = 64'sd20037508343;

    localparam logic [1:0] CfgOriginLat = 2'd0;
    localparam logic [1:0] CfgOriginLon = 2'd1;
    localparam logic [1:0] CfgRotation  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_N1, ST_N2, ST_H, ST_LA, ST_ROT_LA, ST_ROT_H, ST_S, ST_SS,
        ST_SQRT, ST_VEC, ST_E, ST_AR, ST_ROT_AR, ST_MX1, ST_MX2, ST_MY1, ST_MY2,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {MUL_SH17, MUL_SH32, MUL_SH33, MUL_SH60} t_mul_shift;
    typedef enum logic {CORDIC_ROTATE, CORDIC_VECTOR} t_cordic_mode;

    typedef struct packed {
        logic       start;
        t_mul_shift shift;
    } t_mul_req;

    typedef struct packed {
        logic         start;
        t_cordic_mode mode;
    } t_cordic_req;

    // floor(num * 2^sh / den) by restoring long division, den below 2^63
    function automatic logic [63:0] udiv_shift(input logic [63:0] num, input int sh,
                                               input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        logic        b;
        int          i;
        q = '0;
        r = '0;
        for (i = 0; i < 64 + sh; i++) begin
            b = (i < 64) ? num[63 - i] : 1'b0;
            r = {r[62:0], b};
            if (r >= den) begin
                r = r - den;
                q = {q[62:0], 1'b1};
            end else begin
                q = {q[62:0], 1'b0};
            end
        end
        return q;
    endfunction

    // atan(2^-i) in q60, from the alternating series
    function automatic logic [CordicSteps*64-1:0] build_atan_tab();
        logic [CordicSteps*64-1:0] tab;
        logic signed [63:0]        acc;
        logic signed [63:0]        t;
        int                        i;
        int                        k;
        tab = '0;
        tab[63:0] = (PiQ62 + 64'd8) >> 4;
        for (i = 1; i < CordicSteps; i++) begin
            acc = '0;
            for (k = 0; (2 * k + 1) * i <= 62; k++) begin
                t = signed'(udiv_shift(64'd1 << (62 - (2 * k + 1) * i), 0, 64'(2 * k + 1)));
                acc = (k % 2 == 1) ? acc - t : acc + t;
            end
            tab[i*64 +: 64] = (acc + 64'sd2) >>> 2;
        end
        return tab;
    endfunction

    localparam logic [CordicSteps*64-1:0] AtanTab = build_atan_tab();

    // vectoring gain of the full cordic run on a unit vector
    function automatic logic [63:0] cordic_gain();
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        int                 i;
        x = signed'(OneQ60);
        y = '0;
        for (i = 0; i < CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
            end else begin
                x = x - dx;
                y = y + dy;
            end
        end
        return x;
    endfunction

    localparam logic [63:0] InvGain   = udiv_shift(OneQ60, 60, cordic_gain());
    localparam logic [63:0] RadFactor = udiv_shift(PiQ62, 30, UnitsHalfTurn);

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [35:0] clamp_out(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > OutLimit) c = OutLimit;
        if (v < -OutLimit) c = -OutLimit;
        return 36'(c);
    endfunction

endpackage

// ----- hw/rtl/gfl_mul.sv -----
// 64x64 rounded multiply-shift over one 32x32 multiplier, one partial product at a time
module gfl_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gfl_pkg::t_mul_req   i_req,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    output logic                o_done,
    output logic [63:0]         o_result
);
    localparam logic [2:0] LastPp  = 3'd3;
    localparam logic [2:0] LastCnt = 3'd5;

    logic                r_busy;
    logic                r_done;
    logic [2:0]          r_cnt;
    logic [63:0]         r_a;
    logic [63:0]         r_b;
    gfl_pkg::t_mul_shift r_shift;
    logic [63:0]         r_pp;
    logic [1:0]          r_pp_sel;
    logic [127:0]        r_acc;
    logic [63:0]         r_result;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp;
    logic [127:0] pp_aligned;
    logic [127:0] rnd_add;
    logic [127:0] rnd_sum;
    logic [63:0]  rounded;

    assign a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign pp     = a_part * b_part;

    always_comb begin
        case (r_pp_sel)
            2'd0:    pp_aligned = {64'd0, r_pp};
            2'd3:    pp_aligned = {r_pp, 64'd0};
            default: pp_aligned = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_comb begin
        case (r_shift)
            gfl_pkg::MUL_SH17: rnd_add = 128'd1 << 16;
            gfl_pkg::MUL_SH32: rnd_add = 128'd1 << 31;
            gfl_pkg::MUL_SH33: rnd_add = 128'd1 << 32;
            default:           rnd_add = 128'd1 << 59;
        endcase
        rnd_sum = r_acc + rnd_add;
        case (r_shift)
            gfl_pkg::MUL_SH17: rounded = rnd_sum[80:17];
            gfl_pkg::MUL_SH32: rounded = rnd_sum[95:32];
            gfl_pkg::MUL_SH33: rounded = rnd_sum[96:33];
            default:           rounded = rnd_sum[123:60];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LastCnt);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LastCnt) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_shift <= i_req.shift;
            r_acc   <= '0;
        end else if (r_busy) begin
            if (r_cnt <= LastPp) begin
                r_pp     <= pp;
                r_pp_sel <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + pp_aligned;
            end
            if (r_cnt == LastCnt) begin
                r_result <= rounded;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;
endmodule

// ----- hw/rtl/gfl_cordic.sv -----
// iterative cordic, one micro-rotation per cycle, rotate or vector mode
module gfl_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gfl_pkg::t_cordic_req  i_req,
    input  logic signed [63:0]    i_x,
    input  logic signed [63:0]    i_y,
    input  logic signed [63:0]    i_z,
    output logic                  o_done,
    output logic signed [63:0]    o_x,
    output logic signed [63:0]    o_y,
    output logic signed [63:0]    o_z
);
    localparam logic [5:0] LastStep = 6'(gfl_pkg::CordicSteps - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [5:0]            r_step;
    gfl_pkg::t_cordic_mode r_mode;
    logic signed [63:0]    r_x;
    logic signed [63:0]    r_y;
    logic signed [63:0]    r_z;

    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] ang;
    logic               turn_pos;

    assign dx  = r_y >>> r_step;
    assign dy  = r_x >>> r_step;
    assign ang = signed'(gfl_pkg::AtanTab[r_step*64 +: 64]);
    // positive turn: x -= dx, y += dy, z -= atan
    assign turn_pos = (r_mode == gfl_pkg::CORDIC_VECTOR) ? (r_y < 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == LastStep);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_step == LastStep) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
        end else if (r_busy) begin
            if (turn_pos) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ang;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ang;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

// ----- hw/rtl/gfl_isqrt.sv -----
// integer square root, two radicand bits per cycle
module gfl_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_v,
    output logic        o_done,
    output logic [63:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;

    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_bit == 64'd1);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 64'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_v;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r;
endmodule

// ----- hw/rtl/gps_fix_to_local_plane.sv -----
// gps fix to local plane; a fix with unchanged longitude skips the east steps
// cost per fix: 12 multiplies on one 32x32 multiplier, 4 cordic passes and one square root,
// 7 multiplies, one cordic pass and no square root with unchanged longitude; the next fix is taken only when idle
// a new fix is not taken before the last one is done; the arming fix leaves the block idle
// a finished result sits in the output register while the next fix is taken
// synchronous active-low reset: origin and rotation go to defaults, block disarmed
module gps_fix_to_local_plane (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // latitude[30:0], longitude[62:31], zero pad
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [143:0] o_m_axis_tdata,   // east_mm, north_mm, map_x_mm, map_y_mm, 36 each
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
`include "assert_macros.svh"

    // config registers
    logic signed [30:0] r_org_lat;
    logic signed [31:0] r_org_lon;
    logic signed [15:0] r_rot;

    // control
    gfl_pkg::t_state r_state;
    gfl_pkg::t_state n_state;
    logic            r_issued;
    logic            n_issued;
    logic            r_armed;
    logic            r_out_valid;

    // working registers
    logic signed [31:0]  r_dlat;
    logic signed [32:0]  r_dlon;
    logic signed [30:0]  r_lat;
    logic [63:0]         r_t;
    logic signed [63:0]  r_h;
    logic signed [63:0]  r_la;
    logic signed [63:0]  r_cl;
    logic signed [63:0]  r_sh;
    logic [63:0]         r_s;
    logic [63:0]         r_u;
    logic [63:0]         r_cq;
    logic [63:0]         r_z;
    logic signed [35:0]  r_e;
    logic signed [35:0]  r_n;
    logic [63:0]         r_ar;
    logic                r_neg_c;
    logic signed [63:0]  r_ca;
    logic signed [63:0]  r_sa;
    logic signed [63:0]  r_mx;
    logic signed [63:0]  r_my;
    logic [143:0]        r_out_data;

    // arithmetic units; the multiplier and cordic are shared across steps
    gfl_pkg::t_mul_req    mul_req;
    logic [63:0]          mul_a;
    logic [63:0]          mul_b;
    logic                 mul_done;
    logic [63:0]          mul_res;
    gfl_pkg::t_cordic_req cor_req;
    logic signed [63:0]   cor_x0;
    logic signed [63:0]   cor_y0;
    logic signed [63:0]   cor_z0;
    logic                 cor_done;
    logic signed [63:0]   cor_x;
    logic signed [63:0]   cor_y;
    logic signed [63:0]   cor_z;
    logic                 sq_start;
    logic                 sq_done;
    logic [63:0]          sq_root;

    logic               in_accept;
    logic               out_free;
    logic signed [30:0] in_lat;
    logic signed [31:0] in_lon;
    logic signed [63:0] mres;
    logic signed [63:0] mres_neg;
    logic signed [63:0] h_wrap;
    logic signed [63:0] h_fold;
    logic signed [63:0] la_fold;
    logic [63:0]        cl_unit;
    logic [63:0]        sh_unit;
    logic               use_mul;
    logic               use_cor;
    logic               use_sq;
    logic               unit_done;
    gfl_pkg::t_state    step_next;

    assign in_lat    = i_s_axis_tdata[30:0];
    assign in_lon    = i_s_axis_tdata[62:31];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == gfl_pkg::ST_IDLE);

    assign mres     = signed'(mul_res);
    assign mres_neg = -mres;
    // longitude half-angle folded into the first quadrant
    assign h_wrap  = (mres >= signed'(gfl_pkg::PiQ60)) ? mres - signed'(gfl_pkg::PiQ60) : mres;
    assign h_fold  = (h_wrap > signed'(gfl_pkg::HalfPiQ60)) ?
                     signed'(gfl_pkg::PiQ60) - h_wrap : h_wrap;
    assign la_fold = (mres > signed'(gfl_pkg::HalfPiQ60)) ? signed'(gfl_pkg::PiQ60) - mres : mres;
    // |cos| and |sin| capped at one
    assign cl_unit = (gfl_pkg::mag64(r_cl) > gfl_pkg::OneQ60) ?
                     gfl_pkg::OneQ60 : gfl_pkg::mag64(r_cl);
    assign sh_unit = (gfl_pkg::mag64(r_sh) > gfl_pkg::OneQ60) ?
                     gfl_pkg::OneQ60 : gfl_pkg::mag64(r_sh);

    gfl_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    gfl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .i_x     (cor_x0),
        .i_y     (cor_y0),
        .i_z     (cor_z0),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z)
    );

    gfl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_v     ({r_u[61:0], 2'b00}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // sequencer: each step starts one unit once and moves on at its done pulse
    always_comb begin
        n_state       = r_state;
        n_issued      = r_issued;
        use_mul       = 1'b0;
        use_cor       = 1'b0;
        use_sq        = 1'b0;
        step_next     = r_state;
        mul_a         = '0;
        mul_b         = '0;
        mul_req.shift = gfl_pkg::MUL_SH60;
        cor_req.mode  = gfl_pkg::CORDIC_ROTATE;
        cor_x0        = signed'(gfl_pkg::InvGain);
        cor_y0        = '0;
        cor_z0        = '0;
        case (r_state)
            gfl_pkg::ST_IDLE: begin
                if (in_accept && r_armed) begin
                    n_state = gfl_pkg::ST_N1;
                end
            end
            gfl_pkg::ST_N1: begin
                use_mul       = 1'b1;
                mul_a         = gfl_pkg::mag64(64'(r_dlat));
                mul_b         = gfl_pkg::RadFactor;
                mul_req.shift = gfl_pkg::MUL_SH32;
                step_next     = gfl_pkg::ST_N2;
            end
            gfl_pkg::ST_N2: begin
                use_mul   = 1'b1;
                mul_a     = r_t;
                mul_b     = gfl_pkg::RadiusMm;
                // unchanged longitude leaves east at zero
                step_next = (r_dlon == '0) ? gfl_pkg::ST_AR : gfl_pkg::ST_H;
            end
            gfl_pkg::ST_H: begin
                use_mul       = 1'b1;
                mul_a         = gfl_pkg::mag64(64'(r_dlon));
                mul_b         = gfl_pkg::RadFactor;
                mul_req.shift = gfl_pkg::MUL_SH33;
                step_next     = gfl_pkg::ST_LA;
            end
            gfl_pkg::ST_LA: begin
                use_mul       = 1'b1;
                mul_a         = gfl_pkg::mag64(64'(r_lat));
                mul_b         = gfl_pkg::RadFactor;
                mul_req.shift = gfl_pkg::MUL_SH32;
                step_next     = gfl_pkg::ST_ROT_LA;
            end
            gfl_pkg::ST_ROT_LA: begin
                use_cor   = 1'b1;
                cor_z0    = r_la;
                step_next = gfl_pkg::ST_ROT_H;
            end
            gfl_pkg::ST_ROT_H: begin
                use_cor   = 1'b1;
                cor_z0    = r_h;
                step_next = gfl_pkg::ST_S;
            end
            gfl_pkg::ST_S: begin
                use_mul   = 1'b1;
                mul_a     = cl_unit;
                mul_b     = sh_unit;
                step_next = gfl_pkg::ST_SS;
            end
            gfl_pkg::ST_SS: begin
                use_mul   = 1'b1;
                mul_a     = r_s;
                mul_b     = r_s;
                step_next = gfl_pkg::ST_SQRT;
            end
            gfl_pkg::ST_SQRT: begin
                use_sq    = 1'b1;
                step_next = gfl_pkg::ST_VEC;
            end
            gfl_pkg::ST_VEC: begin
                use_cor      = 1'b1;
                cor_req.mode = gfl_pkg::CORDIC_VECTOR;
                cor_x0       = signed'(r_cq);
                cor_y0       = signed'(r_s);
                step_next    = gfl_pkg::ST_E;
            end
            gfl_pkg::ST_E: begin
                use_mul   = 1'b1;
                mul_a     = r_z;
                mul_b     = gfl_pkg::TwoRadiusMm;
                step_next = gfl_pkg::ST_AR;
            end
            gfl_pkg::ST_AR: begin
                use_mul       = 1'b1;
                mul_a         = gfl_pkg::mag64(64'(r_rot));
                mul_b         = gfl_pkg::PiQ62;
                mul_req.shift = gfl_pkg::MUL_SH17;
                step_next     = gfl_pkg::ST_ROT_AR;
            end
            gfl_pkg::ST_ROT_AR: begin
                use_cor   = 1'b1;
                cor_z0    = signed'(r_ar);
                step_next = gfl_pkg::ST_MX1;
            end
            gfl_pkg::ST_MX1: begin
                use_mul   = 1'b1;
                mul_a     = gfl_pkg::mag64(64'(r_e));
                mul_b     = gfl_pkg::mag64(r_ca);
                step_next = gfl_pkg::ST_MX2;
            end
            gfl_pkg::ST_MX2: begin
                use_mul   = 1'b1;
                mul_a     = gfl_pkg::mag64(64'(r_n));
                mul_b     = gfl_pkg::mag64(r_sa);
                step_next = gfl_pkg::ST_MY1;
            end
            gfl_pkg::ST_MY1: begin
                use_mul   = 1'b1;
                mul_a     = gfl_pkg::mag64(64'(r_e));
                mul_b     = gfl_pkg::mag64(r_sa);
                step_next = gfl_pkg::ST_MY2;
            end
            gfl_pkg::ST_MY2: begin
                use_mul   = 1'b1;
                mul_a     = gfl_pkg::mag64(64'(r_n));
                mul_b     = gfl_pkg::mag64(r_ca);
                step_next = gfl_pkg::ST_DONE;
            end
            gfl_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = gfl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gfl_pkg::ST_IDLE;
            end
        endcase

        mul_req.start = use_mul && !r_issued;
        cor_req.start = use_cor && !r_issued;
        sq_start      = use_sq && !r_issued;
        unit_done     = (use_mul && mul_done) || (use_cor && cor_done) || (use_sq && sq_done);
        if (use_mul || use_cor || use_sq) begin
            n_issued = !unit_done;
            if (unit_done) begin
                n_state = step_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfl_pkg::ST_IDLE;
            r_issued    <= 1'b0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
            r_org_lat   <= 31'sd316495779;
            r_org_lon   <= 32'sd1215906371;
            r_rot       <= -16'sd15341;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            // the first fix only arms the block
            if (in_accept && !r_armed) begin
                r_armed <= 1'b1;
            end
            if (r_state == gfl_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gfl_pkg::CfgOriginLat: r_org_lat <= i_cfg_data[30:0];
                    gfl_pkg::CfgOriginLon: r_org_lon <= i_cfg_data;
                    gfl_pkg::CfgRotation:  r_rot     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath captures the fix at accept, each unit's result at its done pulse, the output at done
    always_ff @(posedge i_clk) begin
        if (r_state == gfl_pkg::ST_IDLE && in_accept) begin
            r_lat  <= in_lat;
            r_dlat <= 32'(in_lat) - 32'(r_org_lat);
            r_dlon <= 33'(in_lon) - 33'(r_org_lon);
            r_e    <= '0;
        end
        case (r_state)
            gfl_pkg::ST_N1: if (mul_done) r_t <= mul_res;
            gfl_pkg::ST_N2: if (mul_done) r_n <= gfl_pkg::clamp_out((r_dlat > 0) ? mres : mres_neg);
            gfl_pkg::ST_H:  if (mul_done) r_h <= h_fold;
            gfl_pkg::ST_LA: if (mul_done) r_la <= la_fold;
            gfl_pkg::ST_ROT_LA: if (cor_done) r_cl <= cor_x;
            gfl_pkg::ST_ROT_H:  if (cor_done) r_sh <= cor_y;
            gfl_pkg::ST_S: begin
                if (mul_done) begin
                    r_s <= (mul_res > gfl_pkg::OneQ60) ? gfl_pkg::OneQ60 : mul_res;
                end
            end
            gfl_pkg::ST_SS:   if (mul_done) r_u <= gfl_pkg::OneQ60 - mul_res;
            gfl_pkg::ST_SQRT: if (sq_done) r_cq <= {sq_root[34:0], 29'd0};
            gfl_pkg::ST_VEC:  if (cor_done) r_z <= cor_z[63] ? 64'd0 : 64'(cor_z);
            gfl_pkg::ST_E: begin
                if (mul_done) r_e <= gfl_pkg::clamp_out((r_dlon > 0) ? mres : mres_neg);
            end
            gfl_pkg::ST_AR: begin
                if (mul_done) begin
                    // angle past a right angle: fold and flip the cosine
                    if (mres > signed'(gfl_pkg::HalfPiQ60)) begin
                        r_ar    <= gfl_pkg::PiQ60 - mul_res;
                        r_neg_c <= 1'b1;
                    end else begin
                        r_ar    <= mul_res;
                        r_neg_c <= 1'b0;
                    end
                end
            end
            gfl_pkg::ST_ROT_AR: begin
                if (cor_done) begin
                    r_ca <= r_neg_c ? -cor_x : cor_x;
                    r_sa <= r_rot[15] ? -cor_y : cor_y;
                end
            end
            gfl_pkg::ST_MX1: begin
                if (mul_done) r_mx <= (r_e[35] != r_ca[63]) ? mres_neg : mres;
            end
            gfl_pkg::ST_MX2: begin
                if (mul_done) r_mx <= r_mx - ((r_n[35] != r_sa[63]) ? mres_neg : mres);
            end
            gfl_pkg::ST_MY1: begin
                if (mul_done) r_my <= (r_e[35] != r_sa[63]) ? mres_neg : mres;
            end
            gfl_pkg::ST_MY2: begin
                if (mul_done) r_my <= r_my + ((r_n[35] != r_ca[63]) ? mres_neg : mres);
            end
            gfl_pkg::ST_DONE: begin
                if (out_free) begin
                    r_out_data <= {gfl_pkg::clamp_out(r_my), gfl_pkg::clamp_out(r_mx), r_n, r_e};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `ASSERT_IMPLY(a_mul_done_in_mul_step, i_clk, i_rst_n, mul_done, use_mul, "multiplier done outside a multiply step")
    `ASSERT_IMPLY(a_cor_done_in_cor_step, i_clk, i_rst_n, cor_done, use_cor, "cordic done outside a cordic step")
    `ASSERT_IMPLY(a_sq_done_in_sqrt_step, i_clk, i_rst_n, sq_done, use_sq, "square root done outside its step")
    `ASSERT_NEXT(a_first_fix_arms, i_clk, i_rst_n, (in_accept && !r_armed), (r_armed && r_state == gfl_pkg::ST_IDLE), "first fix did not just arm the block")
endmodule
